### sv/lts_pkg.sv
// Shared types and constants for the 3-D torus Life step unit.
// No dependencies; imported by every module of the block.
package lts_pkg;

   localparam int CUBE_SIZE_DEF = 8;

   // transaction field widths
   localparam int ACTION_W    = 2;
   localparam int COORD_W     = 3;
   localparam int ROW_BITS_W  = 8;
   localparam int LIVE_W      = 10;
   localparam int GEN_W       = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 64;

   // configuration port
   localparam int CFG_W       = 5;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONELY_MAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CROWDED_MIN = 2'd2;

   localparam logic [CFG_W-1:0] BIRTH_COUNT_RESET = 5'd5;
   localparam logic [CFG_W-1:0] LONELY_MAX_RESET  = 5'd3;
   localparam logic [CFG_W-1:0] CROWDED_MIN_RESET = 5'd6;

   // action codes; every other code behaves as a read
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

   typedef struct packed {
      logic [CFG_W-1:0] birth_count;
      logic [CFG_W-1:0] lonely_max;
      logic [CFG_W-1:0] crowded_min;
   } lts_rule_cfg_type;

   typedef struct packed {
      logic shift_cur;   // rotate the present generation one place
      logic shift_nxt;   // shift the new generation one place
      logic commit;      // copy new generation over present one
   } lts_cell_ctrl_type;

endpackage

### sv/lts_row_cell.sv
// One link of the row ring: holds a present row and a next-generation row.
// Depends on lts_pkg.
module lts_row_cell #(
   parameter int ROW_W = lts_pkg::CUBE_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lts_pkg::lts_cell_ctrl_type ctrl,
   input  logic [ROW_W-1:0]          cur_from_right,
   input  logic [ROW_W-1:0]          nxt_from_right,
   output logic [ROW_W-1:0]          cur_row,
   output logic [ROW_W-1:0]          nxt_row
);
   import lts_pkg::*;

   logic [ROW_W-1:0] cur_ff, cur_in;
   logic [ROW_W-1:0] nxt_ff, nxt_in;

   always_comb begin
      cur_in = cur_ff;
      if (ctrl.commit) begin
         cur_in = nxt_ff;
      end else if (ctrl.shift_cur) begin
         cur_in = cur_from_right;
      end
      nxt_in = ctrl.shift_nxt ? nxt_from_right : nxt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   // next-generation row is payload only
   always_ff @(posedge clock) begin
      nxt_ff <= nxt_in;
   end

   assign cur_row = cur_ff;
   assign nxt_row = nxt_ff;

endmodule

### sv/lts_next_row.sv
// Life rule for one row: 26-neighbor counts with y wrap, then birth/death test.
// Depends on lts_pkg.
module lts_next_row #(
   parameter int CUBE_SIZE = lts_pkg::CUBE_SIZE_DEF
) (
   input  logic [2:0][2:0][CUBE_SIZE-1:0] nb_rows,   // [dz][dx], center is [1][1]
   input  lts_pkg::lts_rule_cfg_type      cfg,
   output logic [CUBE_SIZE-1:0]           next_row
);
   import lts_pkg::*;

   for (genvar y = 0; y < CUBE_SIZE; y++) begin : g_bit
      localparam int YM = (y == 0) ? CUBE_SIZE - 1 : y - 1;
      localparam int YP = (y == CUBE_SIZE - 1) ? 0 : y + 1;

      logic [26:0]      blk;
      logic [CFG_W-1:0] n;

      for (genvar dz = 0; dz < 3; dz++) begin : g_z
         for (genvar dx = 0; dx < 3; dx++) begin : g_x
            assign blk[(dz*3+dx)*3 +: 3] =
               {nb_rows[dz][dx][YM], nb_rows[dz][dx][y], nb_rows[dz][dx][YP]};
         end
      end

      // 3x3x3 block minus the cell itself
      assign n = CFG_W'($countones(blk)) - CFG_W'(nb_rows[1][1][y]);

      always_comb begin
         if (n == cfg.birth_count) begin
            next_row[y] = 1'b1;
         end else if (n <= cfg.lonely_max) begin
            next_row[y] = 1'b0;
         end else if (n >= cfg.crowded_min) begin
            next_row[y] = 1'b0;
         end else begin
            next_row[y] = 1'b1;
         end
      end
   end

endmodule

### sv/life_3d_torus_step_unit.sv
// Every action rotates the whole row ring once past the rule unit, one row per cycle.
// A new request is taken only after the previous response has been published.
// A response waiting on rsp_tready holds the ring at its last step only.
// Reset (synchronous): all cells dead, counters and maxima zero, rule registers
// to 5 / 3 / 6.
module life_3d_torus_step_unit #(
   parameter int CUBE_SIZE = lts_pkg::CUBE_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lts_pkg::REQ_DATA_W-1:0] req_tdata,  // plane_index[2:0], line_index[5:3],
                                                      // row_bits[13:6], zero fill
   input  logic [lts_pkg::ACTION_W-1:0]   req_tuser,  // action[1:0]
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lts_pkg::RSP_DATA_W-1:0] rsp_tdata,  // row_out[7:0], live_count[17:8],
                                                      // generation_count[33:18],
                                                      // peak_population[43:34],
                                                      // peak_generation[59:44],
                                                      // cube_empty[60], zero fill
   // configuration writes
   input  logic                           csr_wen,
   input  logic [lts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lts_pkg::CFG_W-1:0]      csr_wdata
);
   import lts_pkg::*;

   // ring geometry: position p holds row (t + p) mod ROWS at rotation step t,
   // row index = z * CUBE_SIZE + x
   localparam int ROWS  = CUBE_SIZE * CUBE_SIZE;
   localparam int CW    = $clog2(CUBE_SIZE);
   localparam int POP_W = $clog2(ROWS * CUBE_SIZE + 1);
   localparam int AW1   = ((CW > COORD_W) ? CW : COORD_W) + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WRAP} state_type;

   // control
   state_type          state_ff;
   logic [CW-1:0]      x_ff, z_ff;
   logic               rsp_tvalid_ff;

   // rule registers
   lts_rule_cfg_type   cfg_ff;

   // cube statistics
   logic [POP_W-1:0]   population_ff, max_pop_ff, acc_ff;
   logic [GEN_W-1:0]   generation_ff, max_gen_ff;
   logic               empty_ff;

   // request held for the whole rotation
   logic [ACTION_W-1:0]   act_ff;
   logic [COORD_W-1:0]    plane_ff, line_ff;
   logic [ROW_BITS_W-1:0] bits_ff;
   logic [CUBE_SIZE-1:0]  row_cap_ff;

   // response registers
   logic [ROW_BITS_W-1:0] rsp_row_ff;
   logic [LIVE_W-1:0]     rsp_live_ff, rsp_peak_pop_ff;
   logic [GEN_W-1:0]      rsp_gen_ff, rsp_peak_gen_ff;
   logic                  rsp_empty_ff;

   // ring signals
   logic [CUBE_SIZE-1:0]            cur_row [ROWS];
   logic [CUBE_SIZE-1:0]            nxt_row [ROWS];
   logic [2:0][4:0][CUBE_SIZE-1:0]  tap_row;
   logic [2:0][2:0][CUBE_SIZE-1:0]  nb_rows;
   logic [CUBE_SIZE-1:0]            new_row, cur_feed, count_row;
   lts_cell_ctrl_type               cell_ctrl;

   logic req_fire, slot_free, is_step, is_write, hit;
   logic x_first, x_last, z_last, last_row;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign is_step   = (act_ff == ACT_STEP);
   assign is_write  = (act_ff == ACT_WRITE);

   assign x_first  = (x_ff == '0);
   assign x_last   = (x_ff == CW'(CUBE_SIZE - 1));
   assign z_last   = (z_ff == CW'(CUBE_SIZE - 1));
   assign last_row = x_last && z_last;

   // head row matches the request address; an address outside the cube never does
   assign hit = (AW1'(x_ff) == AW1'(line_ff)) && (AW1'(z_ff) == AW1'(plane_ff));

   // ---------------------------------------------------------------------
   // Row ring. Each cell passes its rows one place toward the head; the
   // head row re-enters at the tail (replaced by the write data on a hit).
   // ---------------------------------------------------------------------
   assign cell_ctrl.shift_cur = (state_ff == ST_RUN);
   assign cell_ctrl.shift_nxt = (state_ff == ST_RUN) && is_step;
   assign cell_ctrl.commit    = (state_ff == ST_WRAP) && slot_free && is_step;

   assign cur_feed = (is_write && hit) ? CUBE_SIZE'(bits_ff) : cur_row[0];

   for (genvar p = 0; p < ROWS; p++) begin : g_ring
      logic [CUBE_SIZE-1:0] cur_right, nxt_right;
      if (p == ROWS - 1) begin : g_tail
         assign cur_right = cur_feed;
         assign nxt_right = new_row;
      end else begin : g_body
         assign cur_right = cur_row[p+1];
         assign nxt_right = nxt_row[p+1];
      end
      lts_row_cell #(.ROW_W(CUBE_SIZE)) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl),
         .cur_from_right (cur_right),
         .nxt_from_right (nxt_right),
         .cur_row        (cur_row[p]),
         .nxt_row        (nxt_row[p])
      );
   end

   // ---------------------------------------------------------------------
   // Neighbor taps. Plane offsets of +-CUBE_SIZE wrap on the ring by
   // themselves; line offsets need the edge forms when x is first or last.
   // Line tap order: x-1, x, x+1, x-1 wrapped (x first), x+1 wrapped (x last).
   // ---------------------------------------------------------------------
   for (genvar gz = 0; gz < 3; gz++) begin : g_tap_z
      localparam int PZ = (gz == 0) ? ROWS - CUBE_SIZE : ((gz == 1) ? 0 : CUBE_SIZE);
      for (genvar gx = 0; gx < 5; gx++) begin : g_tap_x
         localparam int PX = (gx == 0) ? ROWS - 1 :
                             (gx == 1) ? 0 :
                             (gx == 2) ? 1 :
                             (gx == 3) ? CUBE_SIZE - 1 : ROWS - CUBE_SIZE + 1;
         localparam int P  = (PZ + PX) % ROWS;
         assign tap_row[gz][gx] = cur_row[P];
      end
      assign nb_rows[gz][0] = x_first ? tap_row[gz][3] : tap_row[gz][0];
      assign nb_rows[gz][1] = tap_row[gz][1];
      assign nb_rows[gz][2] = x_last  ? tap_row[gz][4] : tap_row[gz][2];
   end

   lts_next_row #(.CUBE_SIZE(CUBE_SIZE)) u_rule (
      .nb_rows  (nb_rows),
      .cfg      (cfg_ff),
      .next_row (new_row)
   );

   // row as it stands after this transaction, counted as it passes
   assign count_row = is_step ? new_row : cur_feed;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.birth_count <= BIRTH_COUNT_RESET;
         cfg_ff.lonely_max  <= LONELY_MAX_RESET;
         cfg_ff.crowded_min <= CROWDED_MIN_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_BIRTH_COUNT: cfg_ff.birth_count <= csr_wdata;
            CSR_LONELY_MAX:  cfg_ff.lonely_max  <= csr_wdata;
            CSR_CROWDED_MIN: cfg_ff.crowded_min <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: accept, rotate ROWS rows, then publish the response.
   // Step bookkeeping (maxima, generation) is done at accept time since it
   // only needs the values from before the step.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         x_ff          <= '0;
         z_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
         population_ff <= '0;
         max_pop_ff    <= '0;
         generation_ff <= '0;
         max_gen_ff    <= '0;
         empty_ff      <= 1'b0;
      end else begin
         // in wrap a taken response is replaced by the new one below
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_WRAP)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  act_ff     <= req_tuser;
                  plane_ff   <= req_tdata[COORD_W-1:0];
                  line_ff    <= req_tdata[2*COORD_W-1:COORD_W];
                  bits_ff    <= req_tdata[2*COORD_W+ROW_BITS_W-1:2*COORD_W];
                  acc_ff     <= '0;
                  row_cap_ff <= '0;
                  empty_ff   <= 1'b0;
                  if (req_tuser == ACT_STEP) begin
                     if (population_ff == '0) begin
                        // empty cube: restart counting, maxima untouched
                        empty_ff      <= 1'b1;
                        generation_ff <= GEN_W'(1);
                     end else begin
                        if (population_ff > max_pop_ff) max_pop_ff <= population_ff;
                        if (generation_ff > max_gen_ff) max_gen_ff <= generation_ff;
                        generation_ff <= generation_ff + GEN_W'(1);
                     end
                  end
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               acc_ff <= acc_ff + POP_W'($countones(count_row));
               if (hit) begin
                  row_cap_ff <= count_row;
               end
               if (x_last) begin
                  x_ff <= '0;
                  z_ff <= z_last ? '0 : z_ff + CW'(1);
               end else begin
                  x_ff <= x_ff + CW'(1);
               end
               if (last_row) begin
                  state_ff <= ST_WRAP;
               end
            end
            ST_WRAP: begin
               if (slot_free) begin
                  population_ff   <= acc_ff;
                  rsp_row_ff      <= ROW_BITS_W'(row_cap_ff);
                  rsp_live_ff     <= LIVE_W'(acc_ff);
                  rsp_gen_ff      <= generation_ff;
                  rsp_peak_pop_ff <= LIVE_W'(max_pop_ff);
                  rsp_peak_gen_ff <= max_gen_ff;
                  rsp_empty_ff    <= empty_ff;
                  rsp_tvalid_ff   <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_empty_ff, rsp_peak_gen_ff, rsp_peak_pop_ff,
                        rsp_gen_ff, rsp_live_ff, rsp_row_ff};

`ifndef SYNTHESIS
   // rotation counters sit at the ring origin between transactions
   a_idle_origin: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (x_ff == '0) && (z_ff == '0))
      else $error("row counters off origin while idle");

   // an empty-cube step always reports generation one
   a_empty_gen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_empty_ff |-> rsp_gen_ff == GEN_W'(1))
      else $error("empty-cube response with generation other than one");

   // population never exceeds the cell count
   a_pop_range: assert property (@(posedge clock) disable iff (reset)
      population_ff <= POP_W'(ROWS * CUBE_SIZE))
      else $error("population beyond cube size");

   // a free output slot in wrap publishes and frees the request side
   a_wrap_publish: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRAP && slot_free |=> rsp_tvalid_ff && state_ff == ST_IDLE)
      else $error("wrap did not publish the response");
`endif

endmodule

### sim/torus_life_checker.sv
// Checker for the 3-D torus Life step unit: watches the request, response and
// CSR ports, keeps its own copy of the cube and compares every response.
// Depends on lts_pkg (RTL package); also holds the small package shared with the top.
package lts_tb_pkg;
   import lts_pkg::*;

   // action codes as driven on req_tuser; codes other than write and step act as a read
   typedef enum logic [ACTION_W-1:0] {
      OP_WRITE = ACT_WRITE,
      OP_READ  = 2'd1,
      OP_STEP  = ACT_STEP,
      OP_SPARE = 2'd3
   } cube_op_type;

   // response fields, lowest bits last (packed struct puts the first member on top)
   typedef struct packed {
      logic             cube_empty;
      logic [GEN_W-1:0]  peak_generation;
      logic [LIVE_W-1:0] peak_population;
      logic [GEN_W-1:0]  generation_count;
      logic [LIVE_W-1:0] live_count;
      logic [ROW_BITS_W-1:0] row_out;
   } cube_result_type;
endpackage

module torus_life_checker
   import lts_pkg::*, lts_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]   req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int                    mismatches,
   output int                    answers_due,
   output int                    empty_steps
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE = CUBE_SIZE_DEF;

   lts_rule_cfg_type  rules;
   logic [SIDE-1:0]   cube [SIDE][SIDE];   // [z][x], bit y
   logic [LIVE_W-1:0] live;
   logic [GEN_W-1:0]  gen;
   logic [LIVE_W-1:0] peak_live;
   logic [GEN_W-1:0]  peak_gen;
   cube_result_type   cube_answers [$];

   function automatic int unsigned census();
      int unsigned total;
      total = 0;
      for (int z = 0; z < SIDE; z++)
         for (int x = 0; x < SIDE; x++)
            total += $countones(cube[z][x]);
      return total;
   endfunction

   function automatic int unsigned neighbours(int x, int y, int z);
      int unsigned n;
      n = 0;
      for (int dz = -1; dz <= 1; dz++)
         for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++)
               if (dx != 0 || dy != 0 || dz != 0)
                  n += cube[(z + dz + SIDE) % SIDE][(x + dx + SIDE) % SIDE]
                           [(y + dy + SIDE) % SIDE];
      return n;
   endfunction

   // birth wins over both death limits
   function automatic logic alive_next(int unsigned n);
      if (n == rules.birth_count) return 1'b1;
      if (n <= rules.lonely_max)  return 1'b0;
      if (n >= rules.crowded_min) return 1'b0;
      return 1'b1;
   endfunction

   task automatic next_generation();
      logic [SIDE-1:0] fresh [SIDE][SIDE];
      for (int z = 0; z < SIDE; z++)
         for (int x = 0; x < SIDE; x++)
            for (int y = 0; y < SIDE; y++)
               fresh[z][x][y] = alive_next(neighbours(x, y, z));
      cube = fresh;
   endtask

   task automatic evaluate_request(input cube_op_type op, input logic [COORD_W-1:0] z, x,
                                   input logic [ROW_BITS_W-1:0] bits,
                                   output cube_result_type answer);
      answer = '0;
      case (op)
         OP_WRITE: begin
            cube[z][x] = bits;
            live = LIVE_W'(census());
         end
         OP_STEP: begin
            if (live == 0) begin
               // empty cube: still evolves, generation restarts, maxima kept
               answer.cube_empty = 1'b1;
               next_generation();
               live = LIVE_W'(census());
               gen = GEN_W'(1);
               empty_steps++;
            end else begin
               if (live > peak_live) peak_live = live;
               if (gen > peak_gen)   peak_gen = gen;
               next_generation();
               live = LIVE_W'(census());
               gen = gen + 1'b1;
            end
         end
         default: ;
      endcase
      answer.row_out          = cube[z][x];
      answer.live_count       = live;
      answer.generation_count = gen;
      answer.peak_population  = peak_live;
      answer.peak_generation  = peak_gen;
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      cube_result_type got, want;
      if (reset) begin
         rules.birth_count = BIRTH_COUNT_RESET;
         rules.lonely_max  = LONELY_MAX_RESET;
         rules.crowded_min = CROWDED_MIN_RESET;
         for (int z = 0; z < SIDE; z++)
            for (int x = 0; x < SIDE; x++)
               cube[z][x] = '0;
         live = '0;
         gen = '0;
         peak_live = '0;
         peak_gen = '0;
         cube_answers.delete();
         mismatches = 0;
         empty_steps = 0;
      end else begin
         // response first: it always belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            got = cube_result_type'(rsp_tdata[$bits(cube_result_type)-1:0]);
            if (cube_answers.size() == 0) begin
               $error("response with nothing outstanding: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = cube_answers.pop_front();
               check_field("row_out", 16'(want.row_out), 16'(got.row_out));
               check_field("live_count", 16'(want.live_count), 16'(got.live_count));
               check_field("generation_count", want.generation_count, got.generation_count);
               check_field("peak_population", 16'(want.peak_population),
                           16'(got.peak_population));
               check_field("peak_generation", want.peak_generation, got.peak_generation);
               check_field("cube_empty", 16'(want.cube_empty), 16'(got.cube_empty));
            end
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_BIRTH_COUNT: rules.birth_count = csr_wdata;
               CSR_LONELY_MAX:  rules.lonely_max  = csr_wdata;
               CSR_CROWDED_MIN: rules.crowded_min = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            evaluate_request(cube_op_type'(req_tuser), req_tdata[2:0], req_tdata[5:3],
                             req_tdata[13:6], want);
            cube_answers.push_back(want);
         end
      end
      answers_due = cube_answers.size();
   end

endmodule

### sim/tb_life_3d_torus_step_unit.sv
// Top of the testbench for life_3d_torus_step_unit: clock, reset, stimulus and verdict.
// Depends on lts_pkg, lts_tb_pkg and torus_life_checker (sim/torus_life_checker.sv).
module tb_life_3d_torus_step_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lts_pkg::*;
   import lts_tb_pkg::*;

   localparam int          PHASES          = 8;
   localparam int          ITEMS_PER_PHASE = 175;    // ~1400 random transactions
   localparam int          HOLD_CYCLES     = 600;    // long output back-pressure
   localparam int          SETTLE_CYCLES   = 70;     // extra idle time after the last response
   localparam int          DRAIN_LIMIT     = 20000;
   localparam int unsigned LIMIT_NS        = 10_000_000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // plane_index[2:0], line_index[5:3], row_bits[13:6]
   logic [ACTION_W-1:0]   req_tuser;   // action[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // row_out[7:0], live_count[17:8],
                                       // generation_count[33:18], peak_population[43:34],
                                       // peak_generation[59:44], cube_empty[60]
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   int mismatches, answers_due, empty_steps;

   // knobs shared between the stimulus and the response sink
   bit source_gaps;
   bit sink_stalls;
   bit hold_output;

   // tallies for the closing summary
   int issued, n_write, n_read, n_spare, n_step, n_rules;

   life_3d_torus_step_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   torus_life_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .answers_due (answers_due),
      .empty_steps (empty_steps)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #(LIMIT_NS);
      $display("tb_life_3d_torus_step_unit: done, errors");
      $finish;
   end

   // Response sink. Driven at negedge only; one assignment per step.
   // A requested long hold is counted here so the sender keeps offering meanwhile
   // and the block backs up onto req_tready.
   initial begin : sink
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_output) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Random row pattern: empty, full, single cell or mixed density.
   function automatic logic [ROW_BITS_W-1:0] random_row();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'(1 << $urandom_range(0, 7));
         3:       return 8'($urandom & $urandom);
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one transaction; returns at the negedge after it was taken.
   // req_tvalid stays high across back-to-back transactions.
   task automatic offer(input cube_op_type op, input logic [COORD_W-1:0] z, x,
                        input logic [ROW_BITS_W-1:0] bits);
      if (source_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, bits, x, z};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      issued++;
      case (op)
         OP_WRITE: n_write++;
         OP_STEP:  n_step++;
         OP_SPARE: n_spare++;
         default:  n_read++;
      endcase
   endtask

   // Random address, random content.
   task automatic offer_any(input cube_op_type op);
      offer(op, 3'($urandom), 3'($urandom), random_row());
   endtask

   // Stop offering and wait until every response is back, then let the block go idle.
   task automatic settle();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (answers_due != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Load all three rule registers, one per cycle, with csr_wen held high throughout.
   task automatic load_rules(input logic [CFG_W-1:0] birth, lonely, crowded);
      csr_wen   <= 1'b1;
      csr_index <= CSR_BIRTH_COUNT;
      csr_wdata <= birth;
      @(negedge clock);
      csr_index <= CSR_LONELY_MAX;
      csr_wdata <= lonely;
      @(negedge clock);
      csr_index <= CSR_CROWDED_MIN;
      csr_wdata <= crowded;
      @(negedge clock);
      csr_wen   <= 1'b0;
      n_rules++;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] b, l, c;
      int phase_end;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_READ;
      csr_wen    = 1'b0;
      csr_index  = CSR_BIRTH_COUNT;
      csr_wdata  = '0;
      source_gaps = 1'b1;
      sink_stalls = 1'b1;
      hold_output = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // ---- directed: reset rules, corner rows, the unused action code
      offer(OP_READ,  3'd0, 3'd0, 8'h00);   // fresh cube reads back dead
      offer(OP_WRITE, 3'd0, 3'd0, 8'h01);
      offer(OP_WRITE, 3'd7, 3'd7, 8'hFF);
      offer(OP_WRITE, 3'd3, 3'd5, 8'hA5);
      offer(OP_WRITE, 3'd5, 3'd3, 8'h5A);
      offer(OP_SPARE, 3'd3, 3'd5, 8'hFF);   // unused code: no write, answers as a read
      offer(OP_STEP,  3'd3, 3'd5, 8'h00);
      offer(OP_READ,  3'd7, 3'd7, 8'h00);
      offer(OP_WRITE, 3'd7, 3'd7, 8'h00);
      offer(OP_STEP,  3'd0, 3'd0, 8'hFF);
      settle();

      // birth count out of reach, lonely at its top: everything dies,
      // then a step on the empty cube restarts the generation counter
      load_rules(5'd31, 5'd26, 5'd27);
      offer(OP_STEP, 3'd1, 3'd1, 8'h00);
      offer(OP_STEP, 3'd2, 3'd2, 8'h00);
      settle();

      // birth at zero on an empty cube fills all 512 cells; a full cube survives
      load_rules(5'd0, 5'd25, 5'd27);
      offer(OP_STEP, 3'd4, 3'd4, 8'h00);
      offer(OP_STEP, 3'd6, 3'd1, 8'h00);
      offer(OP_READ, 3'd2, 3'd6, 8'h00);
      settle();

      // crowded limit at zero kills every cell regardless of count
      load_rules(5'd31, 5'd0, 5'd0);
      offer(OP_STEP,  3'd0, 3'd7, 8'h00);
      offer(OP_WRITE, 3'd2, 3'd4, 8'h18);
      offer(OP_STEP,  3'd2, 3'd4, 8'h00);
      settle();

      // ---- random: per phase a rule set, then seed/evolve episodes
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: {b, l, c} = {5'd5, 5'd3, 5'd6};
            1: {b, l, c} = {5'd4, 5'd2, 5'd6};
            2: {b, l, c} = {5'd6, 5'd3, 5'd9};
            3: {b, l, c} = {5'd26, 5'd0, 5'd27};   // nearly everything lives
            default: begin
               b = 5'($urandom_range(2, 9));
               l = 5'($urandom_range(0, 6));
               c = 5'($urandom_range(l + 1, 12));
            end
         endcase
         load_rules(b, l, c);
         // last phase runs both sides flat out
         source_gaps = (p != PHASES - 1);
         sink_stalls = (p != PHASES - 1);
         if (p == 2) hold_output = 1'b1;

         phase_end = issued + ITEMS_PER_PHASE;
         while (issued < phase_end) begin
            // seed some rows, evolve a few generations, peek at the result
            repeat ($urandom_range(1, 12)) offer_any(OP_WRITE);
            repeat ($urandom_range(1, 5)) begin
               offer_any(OP_STEP);
               if ($urandom_range(0, 2) == 0) offer_any(OP_READ);
            end
            if ($urandom_range(0, 9) == 0) offer_any(OP_SPARE);
         end
         settle();
      end

      if (answers_due != 0)
         $error("%0d responses never arrived", answers_due);

      $display("covered %0d writes, %0d reads, %0d unused-code transactions, %0d steps",
               n_write, n_read, n_spare, n_step);
      $display("(%0d on an empty cube) under %0d rule sets, with gaps and a %0d-cycle stall",
               empty_steps, n_rules, HOLD_CYCLES);
      if (mismatches == 0 && answers_due == 0) begin
         $display("tb_life_3d_torus_step_unit: done, clean");
      end else begin
         $display("tb_life_3d_torus_step_unit: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
sv/lts_pkg.sv
sv/lts_row_cell.sv
sv/lts_next_row.sv
sv/life_3d_torus_step_unit.sv
sim/torus_life_checker.sv
sim/tb_life_3d_torus_step_unit.sv
